// ===== sv/wpm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the wildcard pattern matcher: default capacity, wildcard bytes,
// request action codes and the control bundle broadcast to the cell row.
// No dependencies.
package wpm_pkg;

	localparam int PATTERN_MAX_DEF = 32;

	localparam logic [7:0] STAR_BYTE  = 8'h2A;
	localparam logic [7:0] QUERY_BYTE = 8'h3F;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_END    = 2'd3
	} action_t;

	// Broadcast to every cell in the row for one accepted request.
	typedef struct packed {
		logic       clear;      // drop the whole pattern
		logic       load_init;  // restore the initial row from the next pattern
		logic       advance;    // step the row by one text byte
		logic [7:0] sym;        // pattern byte or text byte
	} cell_ctl_t;

endpackage

// ===== sv/wpm_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the wildcard pattern matcher: valid/ready plus payload.
// No dependencies.
interface wpm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;

	modport source (output valid, output action, output symbol, input ready);
	modport sink   (input valid, input action, input symbol, output ready);
endinterface

// ===== sv/wpm_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the wildcard pattern matcher: valid/ready plus payload.
// No dependencies.
interface wpm_rsp_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== sv/wpm_cell.sv =====
`timescale 1ns / 1ps
// One pattern column of the matcher: holds a pattern byte, its loaded flag and
// one bit of the match row. Depends on wpm_pkg.
module wpm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  wpm_pkg::cell_ctl_t ctl,
	input  logic              we,
	input  logic              prev_row,
	input  logic              prev_adv,
	input  logic              prev_init,
	output logic              row_bit,
	output logic              adv_bit,
	output logic              init_bit
);
	import wpm_pkg::*;

	logic       loaded_q;
	logic [7:0] byte_q;
	logic       row_q;
	logic       loaded_d;
	logic [7:0] byte_d;
	logic       is_star;
	logic       is_query;

	assign loaded_d = ctl.clear ? 1'b0 : (we ? 1'b1 : loaded_q);
	assign byte_d   = we ? ctl.sym : byte_q;
	assign is_star  = (byte_q == STAR_BYTE);
	assign is_query = (byte_q == QUERY_BYTE);

	// Leading-star run of the pattern as it will stand after this request.
	assign init_bit = prev_init & loaded_d & (byte_d == STAR_BYTE);

	always_comb begin
		if (!loaded_q) begin
			adv_bit = 1'b0;
		end else if (is_query) begin
			adv_bit = prev_row;
		end else if (is_star) begin
			adv_bit = row_q | prev_adv;
		end else begin
			adv_bit = (byte_q == ctl.sym) & prev_row;
		end
	end

	assign row_bit = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			row_q    <= 1'b0;
		end else begin
			loaded_q <= loaded_d;
			if (ctl.load_init) begin
				row_q <= init_bit;
			end else if (ctl.advance) begin
				row_q <= adv_bit;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

endmodule

// ===== sv/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
// Top level of the wildcard pattern matcher: control, length and overflow
// tracking, the row of wpm_cell columns and the response register.
// Depends on wpm_pkg, wpm_req_if, wpm_rsp_if and wpm_cell.

// Matches a streamed text against a stored pattern in which '?' stands for any
// one byte and '*' for any run of bytes, the empty run included. Load the
// pattern with append requests (a clear request drops it); bytes past
// PATTERN_MAX are dropped and latch the overflow flag until the next clear.
// Then send one text request per byte and an end-of-text request, which
// returns matched and pattern_overflow and rearms the row for the next text.
// An append issued mid-text restarts matching from an empty text. A new
// request is taken each cycle while the response register is empty or
// being drained. The clock period is set by the row of cells: a run of '*'
// columns ripples combinationally like a carry chain across up to
// PATTERN_MAX cells, as does the leading-star chain that rebuilds the
// initial row. The pattern store needs no clearing after reset; the block is
// ready as soon as reset is released.
module wildcard_pattern_matcher #(
	parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	wpm_req_if.sink req,
	wpm_rsp_if.source rsp
);
	import wpm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic                 req_acc;
	logic                 is_clear;
	logic                 is_append;
	logic                 is_text;
	logic                 is_end;
	logic                 full;
	cell_ctl_t            ctl;

	logic [LEN_W-1:0]     len_q;
	logic                 ovf_q;
	logic                 row0_q;

	logic [PATTERN_MAX:0] row_vec;
	logic [PATTERN_MAX:0] adv_vec;
	logic [PATTERN_MAX:0] init_vec;
	logic [PATTERN_MAX-1:0] we_vec;

	logic                 rsp_valid_q;
	logic                 matched_q;
	logic                 ovf_out_q;

	// Take a new request whenever the response register is free or draining.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_acc   = req.valid && req.ready;

	assign is_clear  = req_acc && (req.action == ACT_CLEAR);
	assign is_append = req_acc && (req.action == ACT_APPEND);
	assign is_text   = req_acc && (req.action == ACT_TEXT);
	assign is_end    = req_acc && (req.action == ACT_END);
	assign full      = (len_q == LEN_W'(PATTERN_MAX));

	// Clear, append and end of text all rearm the row from the next pattern.
	assign ctl.clear     = is_clear;
	assign ctl.load_init = is_clear || is_append || is_end;
	assign ctl.advance   = is_text;
	assign ctl.sym       = req.symbol;

	// Column zero: the empty prefix matches only the empty text.
	assign row_vec[0]  = row0_q;
	assign adv_vec[0]  = 1'b0;
	assign init_vec[0] = 1'b1;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		// Write the appended byte into the first free column.
		assign we_vec[i] = is_append && !full && (len_q == LEN_W'(i));

		wpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.we        (we_vec[i]),
			.prev_row  (row_vec[i]),
			.prev_adv  (adv_vec[i]),
			.prev_init (init_vec[i]),
			.row_bit   (row_vec[i+1]),
			.adv_bit   (adv_vec[i+1]),
			.init_bit  (init_vec[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			row0_q <= 1'b1;
		end else begin
			if (is_clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (is_append) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
			if (ctl.load_init) begin
				row0_q <= 1'b1;
			end else if (ctl.advance) begin
				row0_q <= 1'b0;
			end
		end
	end

	// Response register: load on end of text, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (is_end) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_end) begin
			matched_q <= row_vec[len_q];
			ovf_out_q <= ovf_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.matched          = matched_q;
	assign rsp.pattern_overflow = ovf_out_q;

endmodule

// ===== sv/wpm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the wildcard pattern matcher, bound to the top level.
// Depends on wpm_pkg and wildcard_pattern_matcher.
module wpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_action,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_matched,
	input logic       rsp_pattern_overflow
);
	import wpm_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_matched) && $stable(rsp_pattern_overflow))
		else $error("response payload changed while stalled");

	a_end_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_action == ACT_END) |=> rsp_valid)
		else $error("end of text gave no response");

	a_other_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_action != ACT_END) |=> !rsp_valid)
		else $error("response without end of text");

	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_acc && (req_action == ACT_END)))
		else $error("response appeared without a request");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.req_valid            (req.valid),
	.req_ready            (req.ready),
	.req_action           (req.action),
	.rsp_valid            (rsp.valid),
	.rsp_ready            (rsp.ready),
	.rsp_matched          (rsp.matched),
	.rsp_pattern_overflow (rsp.pattern_overflow)
);
